// ----- rtl/ppsc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the protein parsimony site combine block.
package ppsc_pkg;

  localparam int TBL_DEPTH  = 256;
  localparam int TBL_ADDR_W = 8;
  localparam int TBL_COUNT  = 3;
  localparam int EXP_SPAN_W = TBL_COUNT * TBL_ADDR_W;
  localparam int TSEL_W     = 2;
  localparam int WEIGHT_W   = 8;
  localparam int MUTS_W     = 2;
  localparam int PROD_W     = MUTS_W + WEIGHT_W;
  localparam int COST_W     = 32;
  localparam int IN_TUSER_W = 1 + TSEL_W;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMBINE = 1'b1;

  localparam logic [TSEL_W-1:0] TBL_LOW  = 2'd0;
  localparam logic [TSEL_W-1:0] TBL_MID  = 2'd1;
  localparam logic [TSEL_W-1:0] TBL_HIGH = 2'd2;

  localparam logic [MUTS_W-1:0] MUTS_ZERO  = 2'd0;
  localparam logic [MUTS_W-1:0] MUTS_ONE   = 2'd1;
  localparam logic [MUTS_W-1:0] MUTS_TWO   = 2'd2;
  localparam logic [MUTS_W-1:0] MUTS_THREE = 2'd3;

  typedef struct packed {
    logic wr_en;
    logic rd0_en;
    logic rd1_en;
  } tbl_ctl_t;

endpackage

// ----- rtl/protein_parsimony_site_combine_top.sv -----
`timescale 1ns / 1ps
// Top level of the protein parsimony site combine block.
//
// One transaction is accepted per cycle while in_tready is high. A combine transaction passes
// through the stage 1, stage 2 and result registers: the parent set is chosen in the input cycle
// and its bytes address the expansion tables, the one-mutation set is formed from that registered
// read in stage 1 and addresses the tables again, and the two-mutation set is formed in stage 2.
// Each table therefore has two registered read ports and one write port; load
// transactions write in the cycle they are accepted and give no result. The table entries
// carry valid bits cleared by reset, so the block takes transactions right after reset.
// Input is held off only when all three stages are full and the result is not being taken.
module protein_parsimony_site_combine_top #(
  parameter int MASK_BITS = 22
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_tvalid,
  output logic                                           in_tready,
  // table_index, table_word, left_set, right_set, left_one, left_two,
  // right_one, right_two, site_weight, zero fill
  input  logic [((ppsc_pkg::TBL_ADDR_W + ppsc_pkg::WEIGHT_W + 7 * MASK_BITS + 7) / 8) * 8 - 1:0]
                                                         in_tdata,
  // func, table_select
  input  logic [ppsc_pkg::IN_TUSER_W-1:0]                in_tuser,
  input  logic                                           in_tlast,
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  // parent_set, parent_one, parent_two, site_mutations, total_cost, zero fill
  output logic [((3 * MASK_BITS + ppsc_pkg::MUTS_W + ppsc_pkg::COST_W + 7) / 8) * 8 - 1:0]
                                                         out_tdata,
  output logic                                           out_tlast
);
  import ppsc_pkg::*;

  localparam int OUT_TDATA_W = ((3 * MASK_BITS + MUTS_W + COST_W + 7) / 8) * 8;
  localparam int OFS_WORD = TBL_ADDR_W;
  localparam int OFS_LSET = OFS_WORD + MASK_BITS;
  localparam int OFS_RSET = OFS_LSET + MASK_BITS;
  localparam int OFS_LONE = OFS_RSET + MASK_BITS;
  localparam int OFS_LTWO = OFS_LONE + MASK_BITS;
  localparam int OFS_RONE = OFS_LTWO + MASK_BITS;
  localparam int OFS_RTWO = OFS_RONE + MASK_BITS;
  localparam int OFS_WGT  = OFS_RTWO + MASK_BITS;

  typedef logic [MASK_BITS-1:0] mask_t;

  // input fields
  logic                  func;
  logic [TSEL_W-1:0]     tsel;
  logic [TBL_ADDR_W-1:0] tidx;
  mask_t                 tword;
  mask_t                 a, b, a1, a2, b1, b2;
  logic [WEIGHT_W-1:0]   wgt;

  assign func  = in_tuser[0];
  assign tsel  = in_tuser[TSEL_W:1];
  assign tidx  = in_tdata[TBL_ADDR_W-1:0];
  assign tword = in_tdata[OFS_WORD +: MASK_BITS];
  assign a     = in_tdata[OFS_LSET +: MASK_BITS];
  assign b     = in_tdata[OFS_RSET +: MASK_BITS];
  assign a1    = in_tdata[OFS_LONE +: MASK_BITS];
  assign a2    = in_tdata[OFS_LTWO +: MASK_BITS];
  assign b1    = in_tdata[OFS_RONE +: MASK_BITS];
  assign b2    = in_tdata[OFS_RTWO +: MASK_BITS];
  assign wgt   = in_tdata[OFS_WGT +: WEIGHT_W];

  // pipeline handshake
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic out_ready_int, s2_ready, s1_ready, s1_move, s2_move;
  logic in_fire, comb_fire, load_fire;

  assign out_ready_int = !out_valid_r || out_tready;
  assign s2_move       = s2_valid_r && out_ready_int;
  assign s2_ready      = !s2_valid_r || out_ready_int;
  assign s1_move       = s1_valid_r && s2_ready;
  assign s1_ready      = !s1_valid_r || s2_ready;
  assign in_tready     = s1_ready;
  assign in_fire       = in_tvalid && in_tready;
  assign comb_fire     = in_fire && (func == FUNC_COMBINE);
  assign load_fire     = in_fire && (func == FUNC_LOAD);

  // site merge
  mask_t both, any, both1, both2, c1, c2, c3, c4;
  mask_t par, p1_pre, p2_pre;
  logic [MUTS_W-1:0] muts;

  assign both  = a & b;
  assign any   = a | b;
  assign both1 = a1 & b1;
  assign both2 = a2 & b2;
  assign c1    = any & both1;
  assign c2    = (any & both2) | both1;
  assign c3    = any | (a1 & b2) | (b1 & a2);
  assign c4    = a1 | b1 | both2;

  always_comb begin
    priority if (both != '0) begin
      muts = MUTS_ZERO; par = both; p1_pre = c1; p2_pre = c2;
    end else if (c1 != '0) begin
      muts = MUTS_ONE; par = c1; p1_pre = c2; p2_pre = c3;
    end else if (c2 != '0) begin
      muts = MUTS_TWO; par = c2; p1_pre = c3; p2_pre = c4;
    end else begin
      muts = MUTS_THREE; par = c3; p1_pre = c4; p2_pre = a2 | b2;
    end
  end

  // weighted running cost
  logic [COST_W-1:0] cost_r, cost_nxt, cost_sat;
  logic [PROD_W-1:0] prod;
  logic [COST_W:0]   cost_sum;

  assign prod     = PROD_W'(muts) * PROD_W'(wgt);
  assign cost_sum = {1'b0, cost_r} + (COST_W + 1)'(prod);
  assign cost_sat = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];

  always_comb begin
    cost_nxt = cost_r;
    if (comb_fire) begin
      cost_nxt = in_tlast ? '0 : cost_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r <= '0;
    end else begin
      cost_r <= cost_nxt;
    end
  end

  // stage 1: parent chosen, tables read at parent bytes
  mask_t             s1_par_r, s1_p1_r, s1_p2_r;
  logic [MUTS_W-1:0] s1_muts_r;
  logic [COST_W-1:0] s1_total_r;
  logic              s1_last_r;

  // stage 2: one-mutation set done, tables read at its bytes
  mask_t             s2_par_r, s2_p1_r, s2_p2_r;
  logic [MUTS_W-1:0] s2_muts_r;
  logic [COST_W-1:0] s2_total_r;
  logic              s2_last_r;

  // result register
  mask_t             out_par_r, out_p1_r, out_p2_r;
  logic [MUTS_W-1:0] out_muts_r;
  logic [COST_W-1:0] out_total_r;
  logic              out_last_r;

  // tables
  mask_t rd0_data [TBL_COUNT];
  mask_t rd1_data [TBL_COUNT];
  logic [EXP_SPAN_W-1:0] par_ext, p1_ext;
  mask_t exp0, exp1, s1_p1, s2_p2;

  assign par_ext = EXP_SPAN_W'(par);
  assign p1_ext  = EXP_SPAN_W'(s1_p1);

  for (genvar g = 0; g < TBL_COUNT; g++) begin : g_tbl
    tbl_ctl_t ctl;
    assign ctl.wr_en  = load_fire && (tsel == TSEL_W'(g));
    assign ctl.rd0_en = comb_fire;
    assign ctl.rd1_en = s1_move;

    ppsc_expand_tbl #(
      .MASK_BITS(MASK_BITS)
    ) u_tbl (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_addr  (tidx),
      .wr_data  (tword),
      .rd0_addr (par_ext[g * TBL_ADDR_W +: TBL_ADDR_W]),
      .rd1_addr (p1_ext[g * TBL_ADDR_W +: TBL_ADDR_W]),
      .rd0_data (rd0_data[g]),
      .rd1_data (rd1_data[g])
    );
  end

  assign exp0  = rd0_data[0] | rd0_data[1] | rd0_data[2];
  assign exp1  = rd1_data[0] | rd1_data[1] | rd1_data[2];
  assign s1_p1 = s1_p1_r | exp0;
  assign s2_p2 = s2_p2_r | exp1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= comb_fire;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_move;
      end
      if (out_ready_int) begin
        out_valid_r <= s2_move;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (comb_fire) begin
      s1_par_r   <= par;
      s1_p1_r    <= p1_pre;
      s1_p2_r    <= p2_pre;
      s1_muts_r  <= muts;
      s1_total_r <= cost_sat;
      s1_last_r  <= in_tlast;
    end
    if (s1_move) begin
      s2_par_r   <= s1_par_r;
      s2_p1_r    <= s1_p1;
      s2_p2_r    <= s1_p2_r;
      s2_muts_r  <= s1_muts_r;
      s2_total_r <= s1_total_r;
      s2_last_r  <= s1_last_r;
    end
    if (s2_move) begin
      out_par_r   <= s2_par_r;
      out_p1_r    <= s2_p1_r;
      out_p2_r    <= s2_p2;
      out_muts_r  <= s2_muts_r;
      out_total_r <= s2_total_r;
      out_last_r  <= s2_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_total_r, out_muts_r, out_p2_r, out_p1_r, out_par_r});
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/ppsc_expand_tbl.sv -----
`timescale 1ns / 1ps
// One byte-slice expansion table: one write port, two registered read ports.
module ppsc_expand_tbl #(
  parameter int MASK_BITS = 22
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ppsc_pkg::tbl_ctl_t             ctl,
  input  logic [ppsc_pkg::TBL_ADDR_W-1:0] wr_addr,
  input  logic [MASK_BITS-1:0]           wr_data,
  input  logic [ppsc_pkg::TBL_ADDR_W-1:0] rd0_addr,
  input  logic [ppsc_pkg::TBL_ADDR_W-1:0] rd1_addr,
  output logic [MASK_BITS-1:0]           rd0_data,
  output logic [MASK_BITS-1:0]           rd1_data
);
  import ppsc_pkg::*;

  logic [MASK_BITS-1:0] mem_r [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] vld_r;
  logic [MASK_BITS-1:0] rd0_r;
  logic [MASK_BITS-1:0] rd1_r;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd0_en) begin
      rd0_r <= vld_r[rd0_addr] ? mem_r[rd0_addr] : '0;
    end
    if (ctl.rd1_en) begin
      rd1_r <= vld_r[rd1_addr] ? mem_r[rd1_addr] : '0;
    end
  end

  assign rd0_data = rd0_r;
  assign rd1_data = rd1_r;

endmodule

// ----- rtl/ppsc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the protein parsimony site combine block, with its bind.
module ppsc_checker #(
  parameter int MASK_BITS = 22
) (
  input logic                                           clk,
  input logic                                           rst_n,
  input logic                                           out_tvalid,
  input logic                                           out_tready,
  input logic [((3 * MASK_BITS + 2 + 32 + 7) / 8) * 8 - 1:0] out_tdata,
  input logic                                           out_tlast
);

  logic [MASK_BITS-1:0] par;
  logic [1:0]           muts;
  logic [31:0]          total;
  logic                 out_fire;
  logic [31:0]          prev_total_r;
  logic                 prev_last_r;

  assign par      = out_tdata[MASK_BITS-1:0];
  assign muts     = out_tdata[3 * MASK_BITS +: 2];
  assign total    = out_tdata[3 * MASK_BITS + 2 +: 32];
  assign out_fire = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_total_r <= '0;
      prev_last_r  <= 1'b1;
    end else if (out_fire) begin
      prev_total_r <= total;
      prev_last_r  <= out_tlast;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_parent_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && muts != 2'd3 |-> par != '0)
    else $error("empty parent set below full cost");

  a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !prev_last_r |-> total >= prev_total_r)
    else $error("running cost decreased within a sequence");

  a_total_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && prev_last_r |-> total <= 32'd765)
    else $error("running cost not cleared after last site");

endmodule

bind protein_parsimony_site_combine_top ppsc_checker #(.MASK_BITS(MASK_BITS)) u_ppsc_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench: directed and random site/load transactions, predicted and compared.
module testbench;
  import ppsc_pkg::*;

  localparam int MB           = 22;
  localparam int IN_W         = ((TBL_ADDR_W + WEIGHT_W + 7 * MB + 7) / 8) * 8;
  localparam int OUT_W        = ((3 * MB + MUTS_W + COST_W + 7) / 8) * 8;
  localparam int N_RANDOM     = 1735;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 40;

  localparam logic [TSEL_W-1:0] TBL_NONE = 2'd3;

  typedef logic [MB-1:0] aa_mask_t;
  localparam aa_mask_t FULL = '1;

  typedef struct packed {
    logic                  func;
    logic [TSEL_W-1:0]     tsel;
    logic [TBL_ADDR_W-1:0] tidx;
    aa_mask_t              tword;
    aa_mask_t              lset;
    aa_mask_t              rset;
    aa_mask_t              lone;
    aa_mask_t              ltwo;
    aa_mask_t              rone;
    aa_mask_t              rtwo;
    logic [WEIGHT_W-1:0]   weight;
    logic                  last;
  } site_item_t;

  typedef struct packed {
    aa_mask_t            pset;
    aa_mask_t            pone;
    aa_mask_t            ptwo;
    logic [MUTS_W-1:0]   muts;
    logic [COST_W-1:0]   total;
    logic                last;
  } site_result_t;

  typedef struct packed {
    site_item_t   item;
    logic         typed;
    site_result_t res;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic             in_tlast = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  protein_parsimony_site_combine_top #(
    .MASK_BITS(MB)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor state
  aa_mask_t          reach_tbl [TBL_COUNT][TBL_DEPTH];
  logic [COST_W-1:0] cost_acc;
  site_result_t      expected_q[$];
  int                errors = 0;
  int                idle_cycles = 0;
  int                burst_left = 0;

  initial begin
    foreach (reach_tbl[t, i]) reach_tbl[t][i] = '0;
    cost_acc = '0;
  end

  function automatic aa_mask_t one_mut_reach(input aa_mask_t m);
    return reach_tbl[0][m[7:0]] | reach_tbl[1][m[15:8]] |
           reach_tbl[2][TBL_ADDR_W'(m[MB-1:16])];
  endfunction

  // Applies one transaction to the predictor; returns 1 when it yields a result.
  function automatic bit fitch_merge(input site_item_t it, output site_result_t r);
    aa_mask_t both, any, both1, both2, c1, c2, c3, c4, par, p1, p2;
    logic [MUTS_W-1:0] muts;
    logic [COST_W:0]   sum;
    r = '0;
    if (it.func == FUNC_LOAD) begin
      if (it.tsel != TBL_NONE) reach_tbl[it.tsel][it.tidx] = it.tword;
      return 1'b0;
    end
    both  = it.lset & it.rset;
    any   = it.lset | it.rset;
    both1 = it.lone & it.rone;
    both2 = it.ltwo & it.rtwo;
    c1 = any & both1;
    c2 = (any & both2) | both1;
    c3 = any | (it.lone & it.rtwo) | (it.rone & it.ltwo);
    c4 = it.lone | it.rone | both2;
    if (|both) begin
      muts = MUTS_ZERO; par = both; p1 = c1; p2 = c2;
    end else if (|c1) begin
      muts = MUTS_ONE; par = c1; p1 = c2; p2 = c3;
    end else if (|c2) begin
      muts = MUTS_TWO; par = c2; p1 = c3; p2 = c4;
    end else begin
      muts = MUTS_THREE; par = c3; p1 = c4; p2 = it.ltwo | it.rtwo;
    end
    p1 = p1 | one_mut_reach(par);
    p2 = p2 | one_mut_reach(p1);
    sum = {1'b0, cost_acc} + (COST_W + 1)'(muts) * (COST_W + 1)'(it.weight);
    cost_acc = sum[COST_W] ? '1 : sum[COST_W-1:0];
    r = '{pset: par, pone: p1, ptwo: p2, muts: muts, total: cost_acc, last: it.last};
    if (it.last) cost_acc = '0;
    return 1'b1;
  endfunction

  function automatic aa_mask_t rand_mask();
    case ($urandom_range(0, 5))
      0: return aa_mask_t'($urandom);
      1: return aa_mask_t'(1) << $urandom_range(0, MB - 1);
      2: return aa_mask_t'($urandom & $urandom & $urandom);
      3: return '0;
      4: return FULL;
      default: return aa_mask_t'($urandom & $urandom);
    endcase
  endfunction

  function automatic site_item_t rand_item(input int load_pct);
    site_item_t it;
    it.func   = ($urandom_range(0, 99) < load_pct) ? FUNC_LOAD : FUNC_COMBINE;
    it.tsel   = TSEL_W'($urandom_range(0, 3));
    it.tidx   = TBL_ADDR_W'($urandom);
    it.tword  = rand_mask();
    it.lset   = rand_mask();
    it.rset   = rand_mask();
    if ($urandom_range(0, 1)) it.rset = it.rset & ~it.lset;
    it.lone   = rand_mask();
    it.ltwo   = rand_mask();
    it.rone   = rand_mask();
    it.rtwo   = rand_mask();
    case ($urandom_range(0, 7))
      0: it.weight = '0;
      1: it.weight = '1;
      default: it.weight = WEIGHT_W'($urandom);
    endcase
    it.last   = ($urandom_range(0, 15) == 0);
    return it;
  endfunction

  function automatic site_item_t mk_site(input aa_mask_t l, r, l1, l2, r1, r2,
                                         input logic [WEIGHT_W-1:0] w, input logic last);
    return '{func: FUNC_COMBINE, tsel: TBL_NONE, tidx: '1, tword: FULL, lset: l, rset: r,
             lone: l1, ltwo: l2, rone: r1, rtwo: r2, weight: w, last: last};
  endfunction

  function automatic site_item_t mk_load(input logic [TSEL_W-1:0] sel,
                                         input logic [TBL_ADDR_W-1:0] idx, input aa_mask_t word);
    return '{func: FUNC_LOAD, tsel: sel, tidx: idx, tword: word, lset: FULL, rset: FULL,
             lone: FULL, ltwo: FULL, rone: FULL, rtwo: FULL, weight: '1, last: 1'b1};
  endfunction

  function automatic site_result_t mk_res(input aa_mask_t ps, p1, p2,
                                          input logic [MUTS_W-1:0] m,
                                          input logic [COST_W-1:0] tot, input logic last);
    return '{pset: ps, pone: p1, ptwo: p2, muts: m, total: tot, last: last};
  endfunction

  // sender: bursts of random length, random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_item(input site_item_t it, input logic typed, input site_result_t want);
    site_result_t r;
    @(negedge clk);
    in_tdata  <= IN_W'({it.weight, it.rtwo, it.rone, it.ltwo, it.lone, it.rset, it.lset,
                        it.tword, it.tidx});
    in_tuser  <= {it.tsel, it.func};
    in_tlast  <= it.last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (fitch_merge(it, r)) expected_q.push_back(typed ? want : r);
  endtask

  // receiver: stall pattern switches between modes
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_phase = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(50, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_phase <= (rx_phase == 6) ? 0 : rx_phase + 1;
    case (rx_mode)
      RX_OPEN:  out_tready <= 1'b1;
      RX_LIGHT: out_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_tready <= ($urandom_range(0, 3) == 0);
      default:  out_tready <= (rx_phase < 4);
    endcase
  end

  task automatic check_field(input string name, input logic [COST_W-1:0] want, got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    site_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{pset:  out_tdata[MB-1:0],
              pone:  out_tdata[2*MB-1:MB],
              ptwo:  out_tdata[3*MB-1:2*MB],
              muts:  out_tdata[3*MB+MUTS_W-1:3*MB],
              total: out_tdata[3*MB+MUTS_W+COST_W-1:3*MB+MUTS_W],
              last:  out_tlast};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected transaction, expected none actual %0h", $time, got);
      end else begin
        want = expected_q.pop_front();
        check_field("parent_set", COST_W'(want.pset), COST_W'(got.pset));
        check_field("parent_one", COST_W'(want.pone), COST_W'(got.pone));
        check_field("parent_two", COST_W'(want.ptwo), COST_W'(got.ptwo));
        check_field("site_mutations", COST_W'(want.muts), COST_W'(got.muts));
        check_field("total_cost", want.total, got.total);
        check_field("is_last", COST_W'(want.last), COST_W'(got.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  dir_row_t dir_tab[$];

  initial begin
    // tables empty after reset: expansion adds nothing
    dir_tab.push_back('{mk_site(FULL, FULL, '0, '0, '0, '0, 8'd255, 1'b0), 1'b1,
                        mk_res(FULL, '0, '0, MUTS_ZERO, 32'd0, 1'b0)});
    dir_tab.push_back('{mk_site(22'h1, 22'h2, 22'h3, '0, 22'h3, '0, 8'd255, 1'b0), 1'b1,
                        mk_res(22'h3, 22'h3, 22'h3, MUTS_ONE, 32'd255, 1'b0)});
    dir_tab.push_back('{mk_site(22'h1, 22'h2, 22'h1, 22'h3, 22'h2, 22'h3, 8'd255, 1'b0), 1'b1,
                        mk_res(22'h3, 22'h3, 22'h3, MUTS_TWO, 32'd765, 1'b0)});
    // nothing reachable in common, end of sequence
    dir_tab.push_back('{mk_site('0, '0, '0, '0, '0, '0, 8'd255, 1'b1), 1'b1,
                        mk_res('0, '0, '0, MUTS_THREE, 32'd1530, 1'b1)});
    dir_tab.push_back('{mk_site(22'h200000, 22'h200000, '0, '0, '0, '0, 8'd0, 1'b1), 1'b1,
                        mk_res(22'h200000, '0, '0, MUTS_ZERO, 32'd0, 1'b1)});
    dir_tab.push_back('{mk_load(TBL_LOW, 8'hff, FULL), 1'b0, '0});
    dir_tab.push_back('{mk_load(TBL_MID, 8'h00, 22'h155555), 1'b0, '0});
    dir_tab.push_back('{mk_load(TBL_HIGH, 8'h3f, 22'h2aaaaa), 1'b0, '0});
    dir_tab.push_back('{mk_load(TBL_NONE, 8'h80, FULL), 1'b0, '0});
    dir_tab.push_back('{mk_load(TBL_HIGH, 8'hc0, 22'h000001), 1'b0, '0});
    dir_tab.push_back('{mk_load(TBL_LOW, 8'h01, 22'h000400), 1'b0, '0});
    dir_tab.push_back('{mk_load(TBL_MID, 8'h02, 22'h300000), 1'b0, '0});
    dir_tab.push_back('{mk_site(22'h0000ff, 22'h0000ff, '0, '0, '0, '0, 8'd1, 1'b0), 1'b0, '0});
    dir_tab.push_back('{mk_site(22'h3f0000, 22'h00ff00, 22'h3fff00, '0, 22'h3f0100, '0,
                                8'd200, 1'b0), 1'b0, '0});
    dir_tab.push_back('{mk_site(22'h000001, 22'h000002, '0, '0, '0, '0, 8'd255, 1'b1),
                        1'b0, '0});
    dir_tab.push_back('{mk_site(22'h000100, 22'h000200, 22'h000300, 22'h000001, 22'h000300,
                                22'h000001, 8'd128, 1'b0), 1'b0, '0});
    dir_tab.push_back('{mk_site(22'h000001, 22'h000200, 22'h000001, 22'h000200, 22'h000200,
                                22'h000001, 8'd77, 1'b0), 1'b0, '0});
    dir_tab.push_back('{mk_site(FULL, FULL, FULL, FULL, FULL, FULL, 8'd255, 1'b1), 1'b0, '0});

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      pace();
      send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
      end
      pace();
      send_item(rand_item((n < 200) ? 50 : 15), 1'b0, '0);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
